// File: rtl/lmts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmts_pkg;

   // Mode codes as seen in the status register.
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LCD_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_SPRITE_ENABLE = 2'd1;
   localparam logic [1:0] CSR_COMPARE_LINE  = 2'd2;
   localparam logic [1:0] CSR_STAT_ENABLES  = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Bit positions in stat_irq_enables.
   localparam int STAT_EN_HBLANK = 0;
   localparam int STAT_EN_VBLANK = 1;
   localparam int STAT_EN_OAM    = 2;
   localparam int STAT_EN_COINC  = 3;

   localparam int DOT_W   = 10;
   localparam int LINE_W  = 8;
   localparam int CYCLE_W = 6;

   localparam logic [DOT_W-1:0]  HBLANK_CYCLES    = 10'd204;
   localparam logic [DOT_W-1:0]  LINE_CYCLES      = 10'd456;
   localparam logic [DOT_W-1:0]  OAM_CYCLES       = 10'd80;
   localparam logic [DOT_W-1:0]  XFER_CYCLES      = 10'd172;
   localparam logic [DOT_W-1:0]  VBLANK_IRQ_DELAY = 10'd24;
   localparam logic [DOT_W-1:0]  DOT_MAX          = 10'd1023;
   localparam logic [LINE_W-1:0] VBLANK_LINE      = 8'd144;
   localparam logic [LINE_W-1:0] LAST_LINE        = 8'd153;

   typedef struct packed {
      logic [DOT_W-1:0]  dot_count;
      logic [1:0]        mode;
      logic [LINE_W-1:0] line;
      logic              coincidence;
      logic              vblank_pending;
   } lmts_state_type;

   typedef struct packed {
      logic              lcd_enable;
      logic              sprite_enable;
      logic [LINE_W-1:0] compare_line;
      logic [3:0]        stat_irq_enables;
   } lmts_cfg_type;

   typedef struct packed {
      logic [1:0]        mode_now;
      logic [LINE_W-1:0] line_now;
      logic              coincidence;
      logic              stat_irq;
      logic              vblank_irq;
      logic              render_bg;
      logic              render_sprites;
      logic [LINE_W-1:0] rendered_line;
      logic              frame_done;
   } lmts_result_type;

endpackage

`default_nettype wire

// File: rtl/lmts_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lmts_req_if
   import lmts_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CYCLE_W-1:0] cycles_added;

   modport source (output valid, output cycles_added, input ready);
   modport sink   (input valid, input cycles_added, output ready);
endinterface

interface lmts_rsp_if
   import lmts_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [1:0]        mode_now;
   logic [LINE_W-1:0] line_now;
   logic              coincidence;
   logic              stat_irq;
   logic              vblank_irq;
   logic              render_bg;
   logic              render_sprites;
   logic [LINE_W-1:0] rendered_line;
   logic              frame_done;

   modport source (output valid, output mode_now, output line_now, output coincidence,
                   output stat_irq, output vblank_irq, output render_bg,
                   output render_sprites, output rendered_line, output frame_done,
                   input ready);
   modport sink   (input valid, input mode_now, input line_now, input coincidence,
                   input stat_irq, input vblank_irq, input render_bg,
                   input render_sprites, input rendered_line, input frame_done,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/lmts_step.sv
`timescale 1ns / 1ps
`default_nettype none

module lmts_step
   import lmts_pkg::*;
(
   input  lmts_state_type     cur,
   input  lmts_cfg_type       cfg,
   input  logic [CYCLE_W-1:0] cycles_added,
   output lmts_state_type     nxt,
   output lmts_result_type    res
);

   always_comb begin
      logic [DOT_W:0]    sum_v;
      logic [DOT_W-1:0]  dot_v;
      logic [1:0]        mode_v;
      logic [LINE_W-1:0] line_v;
      logic              stat_v;
      logic              vbl_v;

      sum_v  = {1'b0, cur.dot_count} + {{(DOT_W + 1 - CYCLE_W){1'b0}}, cycles_added};
      dot_v  = sum_v[DOT_W] ? DOT_MAX : sum_v[DOT_W-1:0];
      mode_v = cur.mode;
      line_v = cur.line;
      stat_v = 1'b0;
      vbl_v  = 1'b0;
      nxt    = cur;
      res    = '0;

      case (cur.mode)
         MODE_HBLANK: begin
            if (dot_v >= HBLANK_CYCLES) begin
               dot_v  = dot_v - HBLANK_CYCLES;
               line_v = cur.line + 8'd1;
               nxt.coincidence = (line_v == cfg.compare_line);
               if (nxt.coincidence && cfg.stat_irq_enables[STAT_EN_COINC]) begin
                  stat_v = 1'b1;
               end
               if (line_v == VBLANK_LINE) begin
                  mode_v             = MODE_VBLANK;
                  nxt.vblank_pending = 1'b1;
                  res.frame_done     = 1'b1;
               end else begin
                  mode_v = MODE_OAM;
                  if (cfg.lcd_enable && cfg.stat_irq_enables[STAT_EN_OAM]) begin
                     stat_v = 1'b1;
                  end
               end
               // The line that just finished is the one before the increment.
               res.rendered_line  = cur.line;
               res.render_bg      = cfg.lcd_enable;
               res.render_sprites = cfg.sprite_enable;
            end
         end
         MODE_VBLANK: begin
            if (cur.vblank_pending && dot_v >= VBLANK_IRQ_DELAY) begin
               if (cfg.lcd_enable) begin
                  vbl_v = 1'b1;
                  if (cfg.stat_irq_enables[STAT_EN_VBLANK]) begin
                     stat_v = 1'b1;
                  end
               end
               nxt.vblank_pending = 1'b0;
            end
            if (dot_v >= LINE_CYCLES) begin
               dot_v = dot_v - LINE_CYCLES;
               if (cur.line == LAST_LINE) begin
                  line_v = '0;
                  mode_v = MODE_OAM;
                  if (cfg.lcd_enable && cfg.stat_irq_enables[STAT_EN_OAM]) begin
                     stat_v = 1'b1;
                  end
               end else begin
                  line_v = cur.line + 8'd1;
               end
               nxt.coincidence = (line_v == cfg.compare_line);
               if (nxt.coincidence && cfg.stat_irq_enables[STAT_EN_COINC]) begin
                  stat_v = 1'b1;
               end
            end
         end
         default: begin
            // OAM search can finish and fall straight into the transfer check.
            if (cur.mode == MODE_OAM && dot_v >= OAM_CYCLES) begin
               dot_v  = dot_v - OAM_CYCLES;
               mode_v = MODE_XFER;
            end
            if (dot_v >= XFER_CYCLES) begin
               dot_v  = dot_v - XFER_CYCLES;
               mode_v = MODE_HBLANK;
               if (cfg.lcd_enable && cfg.stat_irq_enables[STAT_EN_HBLANK]) begin
                  stat_v = 1'b1;
               end
            end
         end
      endcase

      nxt.dot_count   = dot_v;
      nxt.mode        = mode_v;
      nxt.line        = line_v;
      res.mode_now    = mode_v;
      res.line_now    = line_v;
      res.coincidence = nxt.coincidence;
      res.stat_irq    = stat_v;
      res.vblank_irq  = vbl_v;
   end

endmodule

`default_nettype wire

// File: rtl/lcd_mode_timing_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// req       in   valid/ready        cycles_added
// rsp       out  valid/ready        mode_now .. frame_done, one item per req item
// csr       in   csr_we, no stall   csr_index, csr_wdata
//
// Each req item's result is registered; the timing state updates in the same cycle that the
// item is accepted, so one item per cycle is sustained while rsp keeps taking results.
// The result goes into the output entry, or into the second entry while the first still waits.
// A two-entry output buffer lets req keep taking items while one result waits;
// req.ready drops only once both entries are full.
// Synchronous reset: mode OAM search, line 0, counters and flags cleared, buffer empty.

module lcd_mode_timing_sequencer
   import lmts_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   lmts_req_if.sink               req,
   lmts_rsp_if.source             rsp,
   input  wire                    csr_we,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata
);

   lmts_state_type  state_ff, state_in, state_step;
   lmts_cfg_type    cfg_ff, cfg_in;
   lmts_result_type step_res;
   lmts_result_type out_ff, out_in, skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic            accept, out_take;

   lmts_step u_step (
      .cur          (state_ff),
      .cfg          (cfg_ff),
      .cycles_added (req.cycles_added),
      .nxt          (state_step),
      .res          (step_res)
   );

   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && req.ready;
   assign out_take  = out_valid_ff && rsp.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LCD_ENABLE:    cfg_in.lcd_enable       = csr_wdata[0];
            CSR_SPRITE_ENABLE: cfg_in.sprite_enable    = csr_wdata[0];
            CSR_COMPARE_LINE:  cfg_in.compare_line     = csr_wdata[LINE_W-1:0];
            CSR_STAT_ENABLES:  cfg_in.stat_irq_enables = csr_wdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = accept ? state_step : state_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_res;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = step_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.dot_count      <= '0;
         state_ff.mode           <= MODE_OAM;
         state_ff.line           <= '0;
         state_ff.coincidence    <= 1'b0;
         state_ff.vblank_pending <= 1'b0;
         cfg_ff                  <= '0;
         out_valid_ff            <= 1'b0;
         skid_valid_ff           <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_ff        <= cfg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.mode_now       = out_ff.mode_now;
   assign rsp.line_now       = out_ff.line_now;
   assign rsp.coincidence    = out_ff.coincidence;
   assign rsp.stat_irq       = out_ff.stat_irq;
   assign rsp.vblank_irq     = out_ff.vblank_irq;
   assign rsp.render_bg      = out_ff.render_bg;
   assign rsp.render_sprites = out_ff.render_sprites;
   assign rsp.rendered_line  = out_ff.rendered_line;
   assign rsp.frame_done     = out_ff.frame_done;

   // The second buffer entry only fills behind a waiting first entry.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output entry empty");

   // Vertical blank covers exactly lines 144 to 153.
   a_vblank_lines: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_VBLANK) == (state_ff.line >= VBLANK_LINE))
      else $error("mode and line disagree on vertical blank");

   // The dot counter never rests at or past the end of the current mode.
   a_dot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_HBLANK && state_ff.dot_count < HBLANK_CYCLES) ||
      (state_ff.mode == MODE_VBLANK && state_ff.dot_count < LINE_CYCLES) ||
      (state_ff.mode == MODE_OAM    && state_ff.dot_count < OAM_CYCLES) ||
      (state_ff.mode == MODE_XFER   && state_ff.dot_count < XFER_CYCLES))
      else $error("dot counter beyond mode length");

   // A frame completes only on entry to line 144 in vertical blank.
   a_frame_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.frame_done) |->
         (rsp.mode_now == MODE_VBLANK && rsp.line_now == VBLANK_LINE))
      else $error("frame done outside vertical blank entry");

endmodule

`default_nettype wire

// File: sim/lcd_mode_timing_sequencer_test.sv
`timescale 1ns / 1ps

module lcd_mode_timing_sequencer_test;
   import lmts_pkg::*;

   localparam int RANDOM_PHASES  = 16;
   localparam int PHASE_ITEMS    = 100;
   localparam int IDLE_PERCENT   = 22;
   localparam int STALL_AT       = 1450;
   localparam int STALL_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 1000;

   logic clock;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lmts_req_if req_if ();
   lmts_rsp_if rsp_if ();

   lcd_mode_timing_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted timing state and the register settings it runs under.
   lmts_state_type timing;
   lmts_cfg_type disp_cfg;

   logic [CYCLE_W-1:0] cycle_steps[$];
   lmts_result_type expected_status[$];

   int queued_count = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int vblank_entries = 0;
   int settings_count = 0;
   int frames_seen = 0;
   int vblank_irqs_seen = 0;
   int stat_irqs_seen = 0;
   int renders_seen = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit stalled_once = 0;
   bit failed = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic refresh_coincidence();
      if (timing.line == disp_cfg.compare_line) begin
         timing.coincidence = 1'b1;
         return disp_cfg.stat_irq_enables[STAT_EN_COINC];
      end
      timing.coincidence = 1'b0;
      return 1'b0;
   endfunction

   // Adds the elapsed dots and steps the mode sequencer once.
   function automatic lmts_result_type advance_dots(input logic [CYCLE_W-1:0] dots);
      lmts_result_type r;
      logic [DOT_W:0] sum;
      logic lcd;
      r = '0;
      lcd = disp_cfg.lcd_enable;
      sum = timing.dot_count + dots;
      timing.dot_count = (sum > DOT_MAX) ? DOT_MAX : sum[DOT_W-1:0];
      case (timing.mode)
         MODE_HBLANK: begin
            if (timing.dot_count >= HBLANK_CYCLES) begin
               timing.dot_count -= HBLANK_CYCLES;
               timing.line += 8'd1;
               if (refresh_coincidence()) r.stat_irq = 1'b1;
               if (timing.line == VBLANK_LINE) begin
                  timing.mode = MODE_VBLANK;
                  timing.vblank_pending = 1'b1;
                  r.frame_done = 1'b1;
                  vblank_entries++;
               end else begin
                  timing.mode = MODE_OAM;
                  if (lcd && disp_cfg.stat_irq_enables[STAT_EN_OAM]) r.stat_irq = 1'b1;
               end
               r.rendered_line = timing.line - 8'd1;
               r.render_bg = lcd;
               r.render_sprites = disp_cfg.sprite_enable;
            end
         end
         MODE_VBLANK: begin
            if (timing.vblank_pending && timing.dot_count >= VBLANK_IRQ_DELAY) begin
               // With the display off the pending request is dropped silently.
               if (lcd) begin
                  r.vblank_irq = 1'b1;
                  if (disp_cfg.stat_irq_enables[STAT_EN_VBLANK]) r.stat_irq = 1'b1;
               end
               timing.vblank_pending = 1'b0;
            end
            if (timing.dot_count >= LINE_CYCLES) begin
               timing.dot_count -= LINE_CYCLES;
               if (timing.line == LAST_LINE) begin
                  timing.line = '0;
                  timing.mode = MODE_OAM;
                  if (lcd && disp_cfg.stat_irq_enables[STAT_EN_OAM]) r.stat_irq = 1'b1;
               end else begin
                  timing.line += 8'd1;
               end
               if (refresh_coincidence()) r.stat_irq = 1'b1;
            end
         end
         default: begin
            // OAM search falls straight into the transfer check in the same step.
            if (timing.mode == MODE_OAM && timing.dot_count >= OAM_CYCLES) begin
               timing.dot_count -= OAM_CYCLES;
               timing.mode = MODE_XFER;
            end
            if (timing.dot_count >= XFER_CYCLES) begin
               timing.dot_count -= XFER_CYCLES;
               timing.mode = MODE_HBLANK;
               if (lcd && disp_cfg.stat_irq_enables[STAT_EN_HBLANK]) r.stat_irq = 1'b1;
            end
         end
      endcase
      r.mode_now = timing.mode;
      r.line_now = timing.line;
      r.coincidence = timing.coincidence;
      return r;
   endfunction

   function automatic string describe(input lmts_result_type r);
      return {$sformatf("mode %0d line %0d coinc %0b stat %0b vbl %0b ",
                        r.mode_now, r.line_now, r.coincidence, r.stat_irq, r.vblank_irq),
              $sformatf("bg %0b spr %0b rline %0d frame %0b",
                        r.render_bg, r.render_sprites, r.rendered_line, r.frame_done)};
   endfunction

   // Mostly long steps so that the run gets through whole frames.
   function automatic logic [CYCLE_W-1:0] pick_dots();
      if ($urandom_range(0, 99) < 88) return CYCLE_W'($urandom_range(56, 63));
      return CYCLE_W'($urandom_range(0, 63));
   endfunction

   function automatic lmts_cfg_type pick_display_config(input int phase);
      lmts_cfg_type c;
      int roll;
      if (phase == 1) begin
         c = '0;
      end else if (phase == 2) begin
         c.lcd_enable = 1'b1;
         c.sprite_enable = 1'b1;
         c.compare_line = 8'hFF;
         c.stat_irq_enables = 4'hF;
      end else begin
         c.lcd_enable = ($urandom_range(0, 3) != 0);
         c.sprite_enable = 1'($urandom_range(0, 1));
         c.stat_irq_enables = 4'($urandom_range(0, 15));
         roll = $urandom_range(0, 9);
         if (roll < 5) begin
            c.compare_line = timing.line + 8'($urandom_range(1, 8));
         end else if (roll < 7) begin
            // Matches the line already shown; the flag must not change on the write.
            c.compare_line = timing.line;
         end else if (roll == 7) begin
            c.compare_line = '0;
         end else begin
            c.compare_line = 8'($urandom_range(0, 255));
         end
      end
      // A phase starting on lines 120 to 143 has the display on before the first VBlank entry, off after it.
      if (timing.line >= 8'd120 && timing.line < VBLANK_LINE) begin
         c.lcd_enable = (vblank_entries == 0);
         if (vblank_entries == 0) c.stat_irq_enables[STAT_EN_VBLANK] = 1'b1;
      end
      return c;
   endfunction

   task automatic load_display_config(input lmts_cfg_type c);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_LCD_ENABLE;
      csr_wdata <= CSR_DATA_W'(c.lcd_enable);
      @(posedge clock);
      csr_index <= CSR_SPRITE_ENABLE;
      csr_wdata <= CSR_DATA_W'(c.sprite_enable);
      @(posedge clock);
      csr_index <= CSR_COMPARE_LINE;
      csr_wdata <= CSR_DATA_W'(c.compare_line);
      @(posedge clock);
      csr_index <= CSR_STAT_ENABLES;
      csr_wdata <= CSR_DATA_W'(c.stat_irq_enables);
      @(posedge clock);
      csr_we <= 1'b0;
      disp_cfg = c;
      settings_count++;
   endtask

   task automatic queue_step(input logic [CYCLE_W-1:0] dots);
      cycle_steps.push_back(dots);
      queued_count++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (accepted_count != queued_count || expected_status.size() != 0) @(negedge clock);
   endtask

   // Sender.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_status.push_back(advance_dots(req_if.cycles_added));
            accepted_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (cycle_steps.size() != 0 &&
                ((accepted_count >= 400 && accepted_count < 800) ||
                 (accepted_count >= STALL_AT && accepted_count < STALL_AT + 100) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               req_if.valid <= 1'b1;
               req_if.cycles_added <= cycle_steps.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver and checker.
   always @(posedge clock) begin : status_monitor
      lmts_result_type seen, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.mode_now = rsp_if.mode_now;
            seen.line_now = rsp_if.line_now;
            seen.coincidence = rsp_if.coincidence;
            seen.stat_irq = rsp_if.stat_irq;
            seen.vblank_irq = rsp_if.vblank_irq;
            seen.render_bg = rsp_if.render_bg;
            seen.render_sprites = rsp_if.render_sprites;
            seen.rendered_line = rsp_if.rendered_line;
            seen.frame_done = rsp_if.frame_done;
            checked_count++;
            frames_seen += seen.frame_done;
            vblank_irqs_seen += seen.vblank_irq;
            stat_irqs_seen += seen.stat_irq;
            renders_seen += seen.render_bg;
            if (expected_status.size() == 0) begin
               failed = 1'b1;
               $display("%0t: unexpected item, expected none, got %s", $time, describe(seen));
            end else begin
               want = expected_status.pop_front();
               if (seen !== want) begin
                  failed = 1'b1;
                  $display("%0t: item %0d mismatch", $time, checked_count);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(seen));
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!stalled_once && checked_count >= STALL_AT) begin
            // Hold off long enough for the output buffer to fill and stall the input.
            stalled_once = 1'b1;
            stall_left = STALL_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= (checked_count >= 400 && checked_count < 800) ||
                            ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      lmts_cfg_type c;
      req_if.valid = 1'b0;
      req_if.cycles_added = '0;
      rsp_if.ready = 1'b0;
      timing = '0;
      timing.mode = MODE_OAM;
      disp_cfg = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: each bit of the step on its own, zero and the maximum.
      @(negedge clock);
      queue_step(6'd0);
      queue_step(6'd63);
      for (int b = 0; b < CYCLE_W; b++) queue_step(CYCLE_W'(1) << b);
      queue_step(6'd0);
      wait_drained();

      // Everything on, coincidence on line 1: steps into line 1 with the HBlank, coincidence and OAM pulses.
      c.lcd_enable = 1'b1;
      c.sprite_enable = 1'b1;
      c.compare_line = 8'd1;
      c.stat_irq_enables = 4'hF;
      load_display_config(c);
      @(negedge clock);
      repeat (8) queue_step(6'd63);
      queue_step(6'd21);
      queue_step(6'd42);
      queue_step(6'd0);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_display_config(pick_display_config(phase));
         @(negedge clock);
         repeat (PHASE_ITEMS) queue_step(pick_dots());
         wait_drained();
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      $display("Checked %0d items under %0d register settings, through %0d VBlank entries.",
               checked_count, settings_count, frames_seen);
      $display("Seen %0d VBlank interrupts, %0d status interrupts and %0d line renders.",
               vblank_irqs_seen, stat_irqs_seen, renders_seen);
      if (!failed) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
